[hw/rtl/gps_local_displacement_top_assert.svh]
// Assertion macros shared by the RTL of the displacement block.
`ifndef GPS_LOCAL_DISPLACEMENT_TOP_ASSERT_SVH
`define GPS_LOCAL_DISPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GLD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gld assertion failed");

// Next-cycle implication, checked out of reset.
`define GLD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gld assertion failed");

`endif

[hw/rtl/gld_pkg.sv]
package gld_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int RECENT_SKIP_DEF = 16;

    localparam logic [31:0] Q30_ONE   = 32'd1073741824;
    localparam logic [31:0] M_Q24     = 32'd186763114;
    localparam logic [31:0] E2_Q30    = 32'd7188036;
    localparam logic [31:0] K_Q30     = 32'd652032874;
    localparam logic [31:0] LAT_MAX   = 32'd900000000;
    localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
    localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
    localparam logic [41:0] OUT_SAT   = 42'd2000000000;
    localparam logic signed [32:0] OUT_SAT_S = 33'sd2000000000;

    // APB byte addresses of the configuration registers.
    localparam logic [2:0] ADDR_BIAS = 3'd0;
    localparam logic [2:0] ADDR_MINQ = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_CORDIC, S_SC_CLAMP, S_SC_M1, S_SC_M2, S_SC_D,
        S_NEWT_ST, S_NEWT_WT, S_W_ST, S_W_WT, S_SC_M3, S_SC_M4, S_SC_M5,
        S_SC_M6, S_SC_M7, S_SC_FIN, S_POST, S_PUSH, S_SUMSET, S_SUM,
        S_DIVST, S_DIVWT, S_DIFF, S_MULN, S_RNDN, S_RNDE, S_OUT
    } state_t;

    // Arctangent of 2^-i in units of 1e-7 degree.
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd450000000;
            5'd1:  v = 32'd265650512;
            5'd2:  v = 32'd140362435;
            5'd3:  v = 32'd71250163;
            5'd4:  v = 32'd35763344;
            5'd5:  v = 32'd17899106;
            5'd6:  v = 32'd8951737;
            5'd7:  v = 32'd4476142;
            5'd8:  v = 32'd2238105;
            5'd9:  v = 32'd1119057;
            5'd10: v = 32'd559529;
            5'd11: v = 32'd279765;
            5'd12: v = 32'd139882;
            5'd13: v = 32'd69941;
            5'd14: v = 32'd34971;
            5'd15: v = 32'd17485;
            5'd16: v = 32'd8743;
            5'd17: v = 32'd4371;
            5'd18: v = 32'd2186;
            5'd19: v = 32'd1093;
            5'd20: v = 32'd546;
            5'd21: v = 32'd273;
            5'd22: v = 32'd137;
            5'd23: v = 32'd68;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/gps_local_displacement_top.sv]
// Channel   Direction  Handshake              Payload
// config    in/out     psel/penable/pready    paddr, pwdata, prdata
// fix       in         in_valid/in_ready      latitude, longitude, altitude_mm, satellites
// result    out        out_valid/out_ready    north_mm .. origin_altitude_mm
// One item is processed at a time; in_ready is high only while the sequencer is idle.
// An ordinary item runs from acceptance through the CHECK, POST, DIFF, MULN, RNDN, RNDE and OUT states.
// The first qualifying fix adds 24 CORDIC steps and seven divisions of the one
// bit-serial divider (Newton square root and reciprocal).
// With bias correction an item adds a ring push, a sweep over the window and three divisions for the averages.
// Reset is asynchronous; the ring needs no clearing, only written entries are read.
`include "gps_local_displacement_top_assert.svh"

module gps_local_displacement_top
    import gld_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int RECENT_SKIP = RECENT_SKIP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] altitude_mm,
    input  logic [5:0]         satellites,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] north_mm,
    output logic signed [31:0] east_mm,
    output logic signed [31:0] up_mm,
    output logic               fix_latched,
    output logic signed [30:0] origin_latitude,
    output logic signed [31:0] origin_longitude,
    output logic signed [27:0] origin_altitude_mm
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = 32 + CNT_W;
    localparam int WIN   = (RING_DEPTH - RECENT_SKIP < 1) ? 1 : RING_DEPTH - RECENT_SKIP;
    localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WIN);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    state_t state_reg, state_next;

    // Configuration
    logic       bias_en_reg;
    logic [5:0] min_q_reg;

    // Input item
    logic signed [30:0] lat_in_reg;
    logic signed [31:0] lon_in_reg;
    logic signed [27:0] alt_in_reg;
    logic [5:0]         sats_in_reg;

    // Persistent state
    logic               fix_seen_reg;
    logic signed [31:0] org_lat_reg, org_lon_reg, org_alt_reg;
    logic [31:0]        north_scale_reg, east_scale_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;

    // Scale computation
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [4:0]         it_reg;
    logic [30:0]        c_reg;
    logic [63:0]        v_reg;
    logic [33:0]        r_reg;
    logic [2:0]         newt_reg;
    logic [31:0]        w_reg;
    logic [33:0]        t_reg;

    // Shared multiplier and divider
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] prod_reg;
    logic [34:0] rem_reg;
    logic [63:0] quo_reg;
    logic [33:0] dvs_reg;
    logic [6:0]  div_cnt_reg;
    logic [34:0] div_sh;
    logic        div_ge;

    // Ring sweep
    logic [95:0]        ring_mem [RING_DEPTH];
    logic [95:0]        ring_rdata_reg;
    logic               ring_we, ring_re;
    logic [IDX_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   n_reg, iss_reg, acc_reg;
    logic               acc_vld_reg;
    logic signed [SUM_W-1:0] sum_lat_reg, sum_lon_reg, sum_alt_reg;
    logic [1:0]         sel_reg;
    logic               sum_neg_reg;

    // Displacement
    logic [32:0]        mag_n_reg, mag_e_reg;
    logic               neg_n_reg, neg_e_reg;
    logic signed [31:0] north_res_reg, east_res_reg, up_res_reg;

    // Result register
    logic               out_valid_reg;
    logic signed [31:0] north_out_reg, east_out_reg, up_out_reg;
    logic               fix_out_reg;
    logic signed [30:0] olat_out_reg;
    logic signed [31:0] olon_out_reg;
    logic signed [27:0] oalt_out_reg;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_BIAS: prdata = {31'd0, bias_en_reg};
            ADDR_MINQ: prdata = {26'd0, min_q_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_en_reg <= 1'b0;
            min_q_reg   <= 6'd3;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_BIAS: bias_en_reg <= pwdata[0];
                ADDR_MINQ: min_q_reg   <= pwdata[5:0];
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- helpers
    logic        first_fix;
    logic        sum_done;
    logic [65:0] rnd_sum;
    logic [41:0] rnd_q;
    logic [31:0] rnd_mag;
    logic [31:0] s2_val;
    logic [30:0] d_val;
    logic [34:0] newt_sum;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [32:0] dn, du, up_sat;
    logic signed [33:0] dl, dl_w;
    logic [31:0]        abs_lat;

    assign first_fix = !fix_seen_reg && (sats_in_reg >= min_q_reg);
    assign sum_done  = acc_vld_reg && (acc_reg == n_reg - CNT_W'(1));

    assign div_sh = {rem_reg[33:0], quo_reg[63]};
    assign div_ge = div_sh >= {1'b0, dvs_reg};

    assign rnd_sum = prod_reg + 66'd8388608;
    assign rnd_q   = rnd_sum[65:24];
    assign rnd_mag = (rnd_q > OUT_SAT) ? OUT_SAT[31:0] : rnd_q[31:0];

    assign s2_val   = Q30_ONE - prod_reg[61:30];
    assign d_val    = 31'(Q30_ONE - prod_reg[61:30]);
    assign newt_sum = {1'b0, dvs_reg} + {1'b0, quo_reg[33:0]};

    always_comb
    begin
        case (sel_reg)
            2'd0:    sum_sel = sum_lat_reg;
            2'd1:    sum_sel = sum_lon_reg;
            default: sum_sel = sum_alt_reg;
        endcase
    end
    assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

    assign abs_lat = lat_in_reg[30] ? 32'(-32'(lat_in_reg)) : 32'(lat_in_reg);

    assign dn = 33'(lat_in_reg) - 33'(org_lat_reg);
    assign dl = 34'(lon_in_reg) - 34'(org_lon_reg);
    always_comb
    begin
        if (dl > HALF_TURN)
            dl_w = dl - FULL_TURN;
        else if (dl < -HALF_TURN)
            dl_w = dl + FULL_TURN;
        else
            dl_w = dl;
    end
    assign du = 33'(alt_in_reg) - 33'(org_alt_reg);
    assign up_sat = (du > OUT_SAT_S) ? OUT_SAT_S : ((du < -OUT_SAT_S) ? -OUT_SAT_S : du);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (first_fix)
                    state_next = S_CORDIC;
                else if (fix_seen_reg)
                    state_next = S_POST;
                else
                    state_next = S_OUT;
            end
            S_CORDIC:   if (it_reg == 5'd23) state_next = S_SC_CLAMP;
            S_SC_CLAMP: state_next = S_SC_M1;
            S_SC_M1:    state_next = S_SC_M2;
            S_SC_M2:    state_next = S_SC_D;
            S_SC_D:     state_next = S_NEWT_ST;
            S_NEWT_ST:  state_next = S_NEWT_WT;
            S_NEWT_WT:
            begin
                if (div_cnt_reg == 7'd0)
                    state_next = (newt_reg == 3'd5) ? S_W_ST : S_NEWT_ST;
            end
            S_W_ST:     state_next = S_W_WT;
            S_W_WT:     if (div_cnt_reg == 7'd0) state_next = S_SC_M3;
            S_SC_M3:    state_next = S_SC_M4;
            S_SC_M4:    state_next = S_SC_M5;
            S_SC_M5:    state_next = S_SC_M6;
            S_SC_M6:    state_next = S_SC_M7;
            S_SC_M7:    state_next = S_SC_FIN;
            S_SC_FIN:   state_next = S_POST;
            S_POST:     state_next = bias_en_reg ? S_PUSH : S_DIFF;
            S_PUSH:     state_next = S_SUMSET;
            S_SUMSET:   state_next = S_SUM;
            S_SUM:      if (sum_done) state_next = S_DIVST;
            S_DIVST:    state_next = S_DIVWT;
            S_DIVWT:
            begin
                if (div_cnt_reg == 7'd0)
                    state_next = (sel_reg == 2'd2) ? S_DIFF : S_DIVST;
            end
            S_DIFF:     state_next = S_MULN;
            S_MULN:     state_next = S_RNDN;
            S_RNDN:     state_next = S_RNDE;
            S_RNDE:     state_next = S_OUT;
            S_OUT:      if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        in_ready = 1'b0;
        ring_we  = 1'b0;
        ring_re  = 1'b0;
        mul_a    = 34'd0;
        mul_b    = 32'd0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_SC_M1: begin mul_a = 34'(c_reg); mul_b = 32'(c_reg); end
            S_SC_M2: begin mul_a = 34'(E2_Q30); mul_b = s2_val; end
            S_SC_M3: begin mul_a = 34'(M_Q24); mul_b = w_reg; end
            S_SC_M4: begin mul_a = prod_reg[63:30]; mul_b = 32'(c_reg); end
            S_SC_M5: begin mul_a = t_reg; mul_b = w_reg; end
            S_SC_M6: begin mul_a = prod_reg[63:30]; mul_b = w_reg; end
            S_SC_M7: begin mul_a = prod_reg[63:30]; mul_b = Q30_ONE - E2_Q30; end
            S_MULN:  begin mul_a = 34'(mag_n_reg); mul_b = north_scale_reg; end
            S_RNDN:  begin mul_a = 34'(mag_e_reg); mul_b = east_scale_reg; end
            S_PUSH:  ring_we = 1'b1;
            S_SUM:   ring_re = (iss_reg != n_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------- ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[head_reg] <= {32'(lat_in_reg), lon_in_reg, 32'(alt_in_reg)};
        if (ring_re)
            ring_rdata_reg <= ring_mem[ptr_reg];
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_seen_reg    <= 1'b0;
            org_lat_reg     <= 32'sd0;
            org_lon_reg     <= 32'sd0;
            org_alt_reg     <= 32'sd0;
            north_scale_reg <= 32'd0;
            east_scale_reg  <= 32'd0;
            head_reg        <= '0;
            count_reg       <= '0;
            acc_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CHECK:
                begin
                    if (first_fix)
                    begin
                        fix_seen_reg <= 1'b1;
                        org_lat_reg  <= 32'(lat_in_reg);
                        org_lon_reg  <= lon_in_reg;
                        org_alt_reg  <= 32'(alt_in_reg);
                    end
                end
                S_SC_M5:  east_scale_reg  <= prod_reg[61:30];
                S_SC_FIN: north_scale_reg <= prod_reg[61:30];
                S_PUSH:
                begin
                    head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                    if (count_reg != DEPTH_C)
                        count_reg <= count_reg + CNT_W'(1);
                end
                S_SUMSET: acc_vld_reg <= 1'b0;
                S_SUM:    acc_vld_reg <= (iss_reg != n_reg);
                S_DIVWT:
                begin
                    if (div_cnt_reg == 7'd0)
                    begin
                        case (sel_reg)
                            2'd0:    org_lat_reg <= sum_neg_reg ? -quo_reg[31:0] : quo_reg[31:0];
                            2'd1:    org_lon_reg <= sum_neg_reg ? -quo_reg[31:0] : quo_reg[31:0];
                            default: org_alt_reg <= sum_neg_reg ? -quo_reg[31:0] : quo_reg[31:0];
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lat_in_reg  <= latitude;
            lon_in_reg  <= longitude;
            alt_in_reg  <= altitude_mm;
            sats_in_reg <= satellites;
        end

        if (div_cnt_reg != 7'd0)
        begin
            rem_reg     <= div_ge ? div_sh - {1'b0, dvs_reg} : div_sh;
            quo_reg     <= {quo_reg[62:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 7'd1;
        end

        case (state_reg)
            S_CHECK:
            begin
                north_res_reg <= 32'sd0;
                east_res_reg  <= 32'sd0;
                up_res_reg    <= 32'sd0;
                div_cnt_reg   <= 7'd0;
                cx_reg        <= 34'(K_Q30);
                cy_reg        <= 34'sd0;
                cz_reg        <= (abs_lat > LAT_MAX) ? LAT_MAX : abs_lat;
                it_reg        <= 5'd0;
            end
            S_CORDIC:
            begin
                // Rotate towards the residual angle; shifts round towards minus infinity.
                if (!cz_reg[31])
                begin
                    cx_reg <= cx_reg - (cy_reg >>> it_reg);
                    cy_reg <= cy_reg + (cx_reg >>> it_reg);
                    cz_reg <= cz_reg - atan_lut(it_reg);
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> it_reg);
                    cy_reg <= cy_reg - (cx_reg >>> it_reg);
                    cz_reg <= cz_reg + atan_lut(it_reg);
                end
                it_reg <= it_reg + 5'd1;
            end
            S_SC_CLAMP:
            begin
                if (cx_reg[33])
                    c_reg <= 31'd0;
                else if (cx_reg > 34'(Q30_ONE))
                    c_reg <= Q30_ONE[30:0];
                else
                    c_reg <= cx_reg[30:0];
            end
            S_SC_M1, S_SC_M2, S_SC_M3, S_SC_M5, S_SC_M6, S_SC_M7, S_MULN:
                prod_reg <= mul_a * mul_b;
            S_SC_D:
            begin
                v_reg    <= {3'd0, d_val, 30'd0};
                r_reg    <= 34'(Q30_ONE);
                newt_reg <= 3'd0;
            end
            S_NEWT_ST:
            begin
                quo_reg     <= v_reg;
                rem_reg     <= 35'd0;
                dvs_reg     <= (r_reg == 34'd0) ? 34'd1 : r_reg;
                div_cnt_reg <= 7'd64;
            end
            S_NEWT_WT:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    r_reg    <= newt_sum[34:1];
                    newt_reg <= newt_reg + 3'd1;
                end
            end
            S_W_ST:
            begin
                quo_reg     <= 64'h1000_0000_0000_0000;
                rem_reg     <= 35'd0;
                dvs_reg     <= (r_reg == 34'd0) ? 34'd1 : r_reg;
                div_cnt_reg <= 7'd64;
            end
            S_W_WT:   if (div_cnt_reg == 7'd0) w_reg <= quo_reg[31:0];
            S_SC_M4:
            begin
                t_reg    <= prod_reg[63:30];
                prod_reg <= mul_a * mul_b;
            end
            S_SUMSET:
            begin
                n_reg       <= (count_reg > WIN_C) ? WIN_C : count_reg;
                ptr_reg     <= (count_reg == DEPTH_C) ? head_reg : '0;
                iss_reg     <= '0;
                acc_reg     <= '0;
                sum_lat_reg <= '0;
                sum_lon_reg <= '0;
                sum_alt_reg <= '0;
                sel_reg     <= 2'd0;
            end
            S_SUM:
            begin
                if (iss_reg != n_reg)
                begin
                    ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
                    iss_reg <= iss_reg + CNT_W'(1);
                end
                if (acc_vld_reg)
                begin
                    sum_lat_reg <= sum_lat_reg + SUM_W'($signed(ring_rdata_reg[95:64]));
                    sum_lon_reg <= sum_lon_reg + SUM_W'($signed(ring_rdata_reg[63:32]));
                    sum_alt_reg <= sum_alt_reg + SUM_W'($signed(ring_rdata_reg[31:0]));
                    acc_reg     <= acc_reg + CNT_W'(1);
                end
            end
            S_DIVST:
            begin
                quo_reg     <= 64'(sum_mag);
                rem_reg     <= 35'd0;
                dvs_reg     <= 34'(n_reg);
                sum_neg_reg <= sum_sel[SUM_W-1];
                div_cnt_reg <= 7'd64;
            end
            S_DIVWT:  if (div_cnt_reg == 7'd0) sel_reg <= sel_reg + 2'd1;
            S_DIFF:
            begin
                neg_n_reg  <= dn[32];
                mag_n_reg  <= dn[32] ? 33'(-dn) : 33'(dn);
                neg_e_reg  <= dl_w[33];
                mag_e_reg  <= dl_w[33] ? 33'(-dl_w) : 33'(dl_w);
                up_res_reg <= 32'(up_sat);
            end
            S_RNDN:
            begin
                north_res_reg <= neg_n_reg ? -rnd_mag : rnd_mag;
                prod_reg      <= mul_a * mul_b;
            end
            S_RNDE:   east_res_reg <= neg_e_reg ? -rnd_mag : rnd_mag;
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    north_out_reg <= north_res_reg;
                    east_out_reg  <= east_res_reg;
                    up_out_reg    <= up_res_reg;
                    fix_out_reg   <= fix_seen_reg;
                    olat_out_reg  <= org_lat_reg[30:0];
                    olon_out_reg  <= org_lon_reg;
                    oalt_out_reg  <= org_alt_reg[27:0];
                end
            end
            default: ;
        endcase
    end

    assign out_valid          = out_valid_reg;
    assign north_mm           = north_out_reg;
    assign east_mm            = east_out_reg;
    assign up_mm              = up_out_reg;
    assign fix_latched        = fix_out_reg;
    assign origin_latitude    = olat_out_reg;
    assign origin_longitude   = olon_out_reg;
    assign origin_altitude_mm = oalt_out_reg;

    // ---------------------------------------------------------------- checks
    `GLD_ASSERT_NXT(a_fix_sticky, fix_seen_reg, fix_seen_reg)
    `GLD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `GLD_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
    `GLD_ASSERT_IMP(a_window_nonzero, state_reg == S_SUM, n_reg != '0 && n_reg <= WIN_C)

endmodule
